FILE: src/wsfd_pkg.sv
// wind sensor frame decoder: shared types, character codes, quantity ids and crc helper
// no dependencies; used by wind_sensor_frame_decoder_top
package wsfd_pkg;

  // character codes of the frame format
  localparam logic [7:0] START_CHAR  = 8'h24;   // '$'
  localparam logic [7:0] CODE_S      = 8'h53;   // 'S'
  localparam logic [7:0] CODE_M      = 8'h4D;   // 'M'
  localparam logic [7:0] CODE_W_UP   = 8'h57;   // 'W'
  localparam logic [7:0] CODE_W_LO   = 8'h77;   // 'w'
  localparam logic [7:0] CODE_A_UP   = 8'h41;   // 'A'
  localparam logic [7:0] CODE_A_LO   = 8'h61;   // 'a'
  localparam logic [7:0] CODE_D_UP   = 8'h44;   // 'D'
  localparam logic [7:0] CODE_D_LO   = 8'h64;   // 'd'

  localparam logic [7:0] CRC_POLY    = 8'h07;

  // byte counter and frame length width
  localparam int         HELD_W      = 5;
  // frame length is payload plus start, code and two trailer bytes
  localparam logic [HELD_W-1:0] LEN_S = HELD_W'(2 + 4);
  localparam logic [HELD_W-1:0] LEN_M = HELD_W'(4 + 4);
  localparam logic [HELD_W-1:0] LEN_W = HELD_W'(8 + 4);
  localparam logic [HELD_W-1:0] LEN_A = HELD_W'(7 + 4);
  localparam logic [HELD_W-1:0] LEN_D = HELD_W'(12 + 4);

  // payload bytes that are ever read as field data
  localparam int         STORE_LO    = 2;
  localparam int         STORE_HI    = 13;

  // largest number of results for one frame
  localparam int         MAX_RES     = 7;
  localparam int         CNT_W       = 3;

  // quantity ids
  localparam logic [3:0] QID_NONE     = 4'd0;
  localparam logic [3:0] QID_BANK     = 4'd1;
  localparam logic [3:0] QID_PITCH    = 4'd2;
  localparam logic [3:0] QID_HEADING  = 4'd3;
  localparam logic [3:0] QID_CIRCLE   = 4'd4;
  localparam logic [3:0] QID_LIVE_DIR = 4'd5;
  localparam logic [3:0] QID_LIVE_SPD = 4'd6;
  localparam logic [3:0] QID_AVG_DIR  = 4'd7;
  localparam logic [3:0] QID_AVG_SPD  = 4'd8;
  localparam logic [3:0] QID_GND_SPD  = 4'd9;
  localparam logic [3:0] QID_TAS      = 4'd10;
  localparam logic [3:0] QID_TRACK    = 4'd11;
  localparam logic [3:0] QID_TEMP     = 4'd12;
  localparam logic [3:0] QID_PITOT    = 4'd13;
  localparam logic [3:0] QID_FL       = 4'd14;

  // frame status codes
  typedef enum logic [1:0] {
    STAT_PARSED   = 2'd0,
    STAT_CRC_ERR  = 2'd1,
    STAT_UNPARSED = 2'd2
  } status_t;

  // kind of the open frame, taken from its code byte
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ATT,
    KIND_WIND,
    KIND_DATA,
    KIND_PLAIN
  } kind_t;

  // one result item
  typedef struct packed {
    logic [3:0]         qid;
    logic signed [15:0] value;
    logic               valid;
    status_t            status;
    logic               last;
  } result_t;

  // crc-8, msb first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // inclusive signed range check
  function automatic logic in_rng(input logic signed [15:0] v,
                                  input logic signed [15:0] lo,
                                  input logic signed [15:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

FILE: src/wind_sensor_frame_decoder_top.sv
// wind sensor frame decoder: byte parser, crc check, field decode and result buffer
// depends on wsfd_pkg
//
// Takes one received byte per request and may take a new byte in every cycle. Bytes
// outside a frame are dropped; a frame opens on '$' and its code byte fixes the length
// (S 6, M 8, A/a 11, W/w 12, D/d 16 bytes). On the last byte the crc-8 over the frame is
// checked and all results of the frame (one to seven) are loaded at once into a
// seven-entry result buffer, which hands them out one per cycle while out_ready is high,
// with last_of_frame on the final one. The input stalls only when a frame completes
// while results of the previous frame are still waiting to be taken. With a free output
// side bytes flow at one per cycle, except that a six-byte S frame closing right behind
// a D frame waits for the last D result to leave; results appear in the next cycle.
module wind_sensor_frame_decoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_quantity_id,
  output logic signed [15:0] out_quantity_value,
  output logic               out_value_valid,
  output logic [1:0]         out_frame_status,
  output logic               out_last_of_frame
);

  localparam logic [wsfd_pkg::HELD_W-1:0] HELD_ZERO = '0;
  localparam logic [wsfd_pkg::HELD_W-1:0] HELD_ONE  = wsfd_pkg::HELD_W'(1);
  localparam logic [wsfd_pkg::HELD_W-1:0] HELD_TWO  = wsfd_pkg::HELD_W'(2);
  localparam logic [wsfd_pkg::CNT_W-1:0]  CNT_ONE   = wsfd_pkg::CNT_W'(1);

  // parser state
  logic [wsfd_pkg::HELD_W-1:0] held_r, held_nxt;
  logic [wsfd_pkg::HELD_W-1:0] len_r, len_nxt;
  logic [7:0]                  crc_r, crc_nxt;
  wsfd_pkg::kind_t             kind_r, kind_nxt;
  logic [7:0]                  store_r [wsfd_pkg::STORE_LO:wsfd_pkg::STORE_HI];

  // result buffer, head at entry 0
  wsfd_pkg::result_t           res_r   [wsfd_pkg::MAX_RES];
  wsfd_pkg::result_t           res_nxt [wsfd_pkg::MAX_RES];
  logic [wsfd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                        in_acc, out_acc, last_pop, closing, finish;
  logic [wsfd_pkg::HELD_W-1:0] held_inc;
  logic [7:0]                  crc_byte, crc_start;
  wsfd_pkg::kind_t             code_kind;
  logic [wsfd_pkg::HELD_W-1:0] code_len;

  // handshakes
  assign out_valid = (cnt_r != '0);
  assign out_acc   = out_valid && out_ready;
  assign last_pop  = out_acc && (cnt_r == CNT_ONE);
  assign held_inc  = held_r + HELD_ONE;
  // the next byte closes the open frame
  assign closing   = (held_r >= HELD_TWO) && (held_inc >= len_r);
  assign in_ready  = !(closing && out_valid && !last_pop);
  assign in_acc    = in_valid && in_ready;

  assign crc_byte  = wsfd_pkg::crc8_byte(crc_r, in_rx_byte);
  assign crc_start = wsfd_pkg::crc8_byte(8'h00, wsfd_pkg::START_CHAR);

  // code byte decode
  always_comb begin
    unique case (in_rx_byte) inside
      wsfd_pkg::CODE_S: begin
        code_kind = wsfd_pkg::KIND_PLAIN;
        code_len  = wsfd_pkg::LEN_S;
      end
      wsfd_pkg::CODE_M: begin
        code_kind = wsfd_pkg::KIND_PLAIN;
        code_len  = wsfd_pkg::LEN_M;
      end
      wsfd_pkg::CODE_W_UP, wsfd_pkg::CODE_W_LO: begin
        code_kind = wsfd_pkg::KIND_WIND;
        code_len  = wsfd_pkg::LEN_W;
      end
      wsfd_pkg::CODE_A_UP, wsfd_pkg::CODE_A_LO: begin
        code_kind = wsfd_pkg::KIND_ATT;
        code_len  = wsfd_pkg::LEN_A;
      end
      wsfd_pkg::CODE_D_UP, wsfd_pkg::CODE_D_LO: begin
        code_kind = wsfd_pkg::KIND_DATA;
        code_len  = wsfd_pkg::LEN_D;
      end
      default: begin
        code_kind = wsfd_pkg::KIND_NONE;
        code_len  = HELD_ZERO;
      end
    endcase
  end

  // byte parser next state
  always_comb begin
    held_nxt = held_r;
    len_nxt  = len_r;
    crc_nxt  = crc_r;
    kind_nxt = kind_r;
    finish   = 1'b0;
    if (in_acc) begin
      if (held_r == HELD_ZERO) begin
        if (in_rx_byte == wsfd_pkg::START_CHAR) begin
          held_nxt = HELD_ONE;
          crc_nxt  = crc_start;
        end
      end else if (held_r == HELD_ONE) begin
        if (code_kind == wsfd_pkg::KIND_NONE) begin
          // unknown code: drop the '$' and rescan this byte
          len_nxt  = HELD_ZERO;
          kind_nxt = wsfd_pkg::KIND_NONE;
          if (in_rx_byte == wsfd_pkg::START_CHAR) begin
            held_nxt = HELD_ONE;
            crc_nxt  = crc_start;
          end else begin
            held_nxt = HELD_ZERO;
            crc_nxt  = 8'h00;
          end
        end else begin
          held_nxt = HELD_TWO;
          len_nxt  = code_len;
          kind_nxt = code_kind;
          crc_nxt  = crc_byte;
        end
      end else if (closing) begin
        finish   = 1'b1;
        held_nxt = HELD_ZERO;
        len_nxt  = HELD_ZERO;
        crc_nxt  = 8'h00;
        kind_nxt = wsfd_pkg::KIND_NONE;
      end else begin
        held_nxt = held_inc;
        crc_nxt  = crc_byte;
      end
    end
  end

  // field decode of a closing frame; the closing byte is never a field byte
  always_comb begin
    logic signed [15:0] d, v;
    logic [7:0]         s;
    logic               ok;
    d = '0;
    v = '0;
    s = '0;
    ok = 1'b0;
    for (int i = 0; i < wsfd_pkg::MAX_RES; i++) begin
      res_nxt[i] = '{qid: wsfd_pkg::QID_NONE, value: '0, valid: 1'b0,
                     status: wsfd_pkg::STAT_PARSED, last: 1'b0};
    end
    cnt_nxt = CNT_ONE;
    if (crc_byte != 8'h00) begin
      res_nxt[0].status = wsfd_pkg::STAT_CRC_ERR;
      res_nxt[0].last   = 1'b1;
    end else begin
      case (kind_r)
        wsfd_pkg::KIND_ATT: begin
          cnt_nxt = wsfd_pkg::CNT_W'(4);
          v = {store_r[2], store_r[3]};
          res_nxt[0] = '{wsfd_pkg::QID_BANK, v, wsfd_pkg::in_rng(v, -16'sd180, 16'sd180),
                         wsfd_pkg::STAT_PARSED, 1'b0};
          v = {{8{store_r[4][7]}}, store_r[4]};
          res_nxt[1] = '{wsfd_pkg::QID_PITCH, v, wsfd_pkg::in_rng(v, -16'sd90, 16'sd90),
                         wsfd_pkg::STAT_PARSED, 1'b0};
          v = {store_r[5], store_r[6]};
          res_nxt[2] = '{wsfd_pkg::QID_HEADING, v, wsfd_pkg::in_rng(v, 16'sd0, 16'sd360),
                         wsfd_pkg::STAT_PARSED, 1'b0};
          v = {store_r[7], store_r[8]};
          res_nxt[3] = '{wsfd_pkg::QID_CIRCLE, v, wsfd_pkg::in_rng(v, 16'sd0, 16'sd1000),
                         wsfd_pkg::STAT_PARSED, 1'b1};
        end
        wsfd_pkg::KIND_WIND: begin
          cnt_nxt = wsfd_pkg::CNT_W'(5);
          // live wind pair shares one flag
          d  = {store_r[2], store_r[3]};
          s  = store_r[4];
          ok = wsfd_pkg::in_rng(d, 16'sd0, 16'sd360) && (s <= 8'd200);
          res_nxt[0] = '{wsfd_pkg::QID_LIVE_DIR, d, ok, wsfd_pkg::STAT_PARSED, 1'b0};
          res_nxt[1] = '{wsfd_pkg::QID_LIVE_SPD, {8'h00, s}, ok,
                         wsfd_pkg::STAT_PARSED, 1'b0};
          // average wind pair
          d  = {store_r[5], store_r[6]};
          s  = store_r[7];
          ok = wsfd_pkg::in_rng(d, 16'sd0, 16'sd360) && (s <= 8'd200);
          res_nxt[2] = '{wsfd_pkg::QID_AVG_DIR, d, ok, wsfd_pkg::STAT_PARSED, 1'b0};
          res_nxt[3] = '{wsfd_pkg::QID_AVG_SPD, {8'h00, s}, ok,
                         wsfd_pkg::STAT_PARSED, 1'b0};
          v = {store_r[8], store_r[9]};
          res_nxt[4] = '{wsfd_pkg::QID_HEADING, v, wsfd_pkg::in_rng(v, 16'sd0, 16'sd360),
                         wsfd_pkg::STAT_PARSED, 1'b1};
        end
        wsfd_pkg::KIND_DATA: begin
          cnt_nxt = wsfd_pkg::CNT_W'(7);
          v = {store_r[2], store_r[3]};
          res_nxt[0] = '{wsfd_pkg::QID_GND_SPD, v, wsfd_pkg::in_rng(v, 16'sd0, 16'sd499),
                         wsfd_pkg::STAT_PARSED, 1'b0};
          v = {store_r[4], store_r[5]};
          res_nxt[1] = '{wsfd_pkg::QID_TAS, v, wsfd_pkg::in_rng(v, 16'sd0, 16'sd499),
                         wsfd_pkg::STAT_PARSED, 1'b0};
          v = {store_r[6], store_r[7]};
          res_nxt[2] = '{wsfd_pkg::QID_TRACK, v, wsfd_pkg::in_rng(v, 16'sd0, 16'sd499),
                         wsfd_pkg::STAT_PARSED, 1'b0};
          v = {store_r[8], store_r[9]};
          res_nxt[3] = '{wsfd_pkg::QID_HEADING, v, wsfd_pkg::in_rng(v, 16'sd0, 16'sd360),
                         wsfd_pkg::STAT_PARSED, 1'b0};
          v = {{8{store_r[10][7]}}, store_r[10]};
          res_nxt[4] = '{wsfd_pkg::QID_TEMP, v, wsfd_pkg::in_rng(v, -16'sd50, 16'sd100),
                         wsfd_pkg::STAT_PARSED, 1'b0};
          v = {{8{store_r[11][7]}}, store_r[11]};
          res_nxt[5] = '{wsfd_pkg::QID_PITOT, v, wsfd_pkg::in_rng(v, 16'sd0, 16'sd100),
                         wsfd_pkg::STAT_PARSED, 1'b0};
          v = {store_r[12], store_r[13]};
          res_nxt[6] = '{wsfd_pkg::QID_FL, v, wsfd_pkg::in_rng(v, 16'sd0, 16'sd300),
                         wsfd_pkg::STAT_PARSED, 1'b1};
        end
        default: begin
          // s or m frame, or nothing open
          res_nxt[0].status = wsfd_pkg::STAT_UNPARSED;
          res_nxt[0].last   = 1'b1;
        end
      endcase
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= HELD_ZERO;
      len_r  <= HELD_ZERO;
      crc_r  <= 8'h00;
      kind_r <= wsfd_pkg::KIND_NONE;
    end else begin
      held_r <= held_nxt;
      len_r  <= len_nxt;
      crc_r  <= crc_nxt;
      kind_r <= kind_nxt;
    end
  end

  // payload byte store
  always_ff @(posedge clk) begin
    for (int i = wsfd_pkg::STORE_LO; i <= wsfd_pkg::STORE_HI; i++) begin
      if (in_acc && (held_r == wsfd_pkg::HELD_W'(i))) begin
        store_r[i] <= in_rx_byte;
      end
    end
  end

  // result buffer count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (finish) begin
      cnt_r <= cnt_nxt;
    end else if (out_acc) begin
      cnt_r <= cnt_r - CNT_ONE;
    end
  end

  // result buffer payload: load a whole frame, shift on each taken result
  always_ff @(posedge clk) begin
    if (finish) begin
      res_r <= res_nxt;
    end else if (out_acc) begin
      for (int i = 0; i < wsfd_pkg::MAX_RES - 1; i++) begin
        res_r[i] <= res_r[i + 1];
      end
    end
  end

  assign out_quantity_id    = res_r[0].qid;
  assign out_quantity_value = res_r[0].value;
  assign out_value_valid    = res_r[0].valid;
  assign out_frame_status   = res_r[0].status;
  assign out_last_of_frame  = res_r[0].last;

  // input held back only while results wait
  a_stall_needs_results: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result buffer");

  // last marker sits on the final buffered result
  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_of_frame == (cnt_r == CNT_ONE)))
    else $error("last_of_frame out of step with result count");

  // open frame never runs past its length
  a_held_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r >= HELD_TWO) |-> (held_r < len_r))
    else $error("byte count reached frame length without closing");

  // a closing byte loads a fresh set of results
  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (out_valid && (cnt_r >= CNT_ONE)))
    else $error("closed frame produced no results");

endmodule
